// ----- src/tcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Telecommand CLTU encoder package
// Shared constants, tables, the queue entry type and the back-end phases.
// ----------------------------------------------------------------------------
package tcc_pkg;

	// Frame and code geometry
	localparam int FRAME_BYTES = 224;
	localparam int FPOS_W      = 11;
	localparam int PN_LEN      = 255;
	localparam int BLOCK_BYTES = 7;

	// Command queue geometry
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Byte kind codes on the output
	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_PARITY = 2'd2;
	localparam logic [1:0] KIND_TAIL   = 2'd3;

	// Fixed sequences
	localparam logic [7:0] START_HI    = 8'heb;
	localparam logic [7:0] START_LO    = 8'h90;
	localparam logic [7:0] TAIL_FILL   = 8'hc5;
	localparam logic [7:0] TAIL_END    = 8'h79;
	localparam logic [7:0] PARITY_MASK = 8'hfe;
	localparam logic [2:0] TAIL_LAST   = 3'd7;

	// Pseudo-noise sequence for the randomiser
	localparam logic [7:0] PN_SEQ [0:PN_LEN-1] = '{
		8'hff,8'h39,8'h9e,8'h5a,8'h68,8'he9,8'h06,8'hf5,8'h6c,8'h89,8'h2f,8'ha1,8'h31,8'h5e,
		8'h08,8'hc0,8'h52,8'ha8,8'hbb,8'hae,8'h4e,8'hc2,8'hc7,8'hed,8'h66,8'hdc,8'h38,8'hd4,
		8'hf8,8'h86,8'h50,8'h3d,8'hfe,8'h73,8'h3c,8'hb4,8'hd1,8'hd2,8'h0d,8'hea,8'hd9,8'h12,
		8'h5f,8'h42,8'h62,8'hbc,8'h11,8'h80,8'ha5,8'h51,8'h77,8'h5c,8'h9d,8'h85,8'h8f,8'hda,
		8'hcd,8'hb8,8'h71,8'ha9,8'hf1,8'h0c,8'ha0,8'h7b,8'hfc,8'he6,8'h79,8'h69,8'ha3,8'ha4,
		8'h1b,8'hd5,8'hb2,8'h24,8'hbe,8'h84,8'hc5,8'h78,8'h23,8'h01,8'h4a,8'ha2,8'hee,8'hb9,
		8'h3b,8'h0b,8'h1f,8'hb5,8'h9b,8'h70,8'he3,8'h53,8'he2,8'h19,8'h40,8'hf7,8'hf9,8'hcc,
		8'hf2,8'hd3,8'h47,8'h48,8'h37,8'hab,8'h64,8'h49,8'h7d,8'h09,8'h8a,8'hf0,8'h46,8'h02,
		8'h95,8'h45,8'hdd,8'h72,8'h76,8'h16,8'h3f,8'h6b,8'h36,8'he1,8'hc6,8'ha7,8'hc4,8'h32,
		8'h81,8'hef,8'hf3,8'h99,8'he5,8'ha6,8'h8e,8'h90,8'h6f,8'h56,8'hc8,8'h92,8'hfa,8'h13,
		8'h15,8'he0,8'h8c,8'h05,8'h2a,8'h8b,8'hba,8'he4,8'hec,8'h2c,8'h7e,8'hd6,8'h6d,8'hc3,
		8'h8d,8'h4f,8'h88,8'h65,8'h03,8'hdf,8'he7,8'h33,8'hcb,8'h4d,8'h1d,8'h20,8'hde,8'had,
		8'h91,8'h25,8'hf4,8'h26,8'h2b,8'hc1,8'h18,8'h0a,8'h55,8'h17,8'h75,8'hc9,8'hd8,8'h58,
		8'hfd,8'hac,8'hdb,8'h87,8'h1a,8'h9f,8'h10,8'hca,8'h07,8'hbf,8'hce,8'h67,8'h96,8'h9a,
		8'h3a,8'h41,8'hbd,8'h5b,8'h22,8'h4b,8'he8,8'h4c,8'h57,8'h82,8'h30,8'h14,8'haa,8'h2e,
		8'heb,8'h93,8'hb0,8'hb1,8'hfb,8'h59,8'hb7,8'h0e,8'h35,8'h3e,8'h21,8'h94,8'h0f,8'h7f,
		8'h9c,8'hcf,8'h2d,8'h34,8'h74,8'h83,8'h7a,8'hb6,8'h44,8'h97,8'hd0,8'h98,8'haf,8'h04,
		8'h60,8'h29,8'h54,8'h5d,8'hd7,8'h27,8'h61,8'h63,8'hf6,8'hb3,8'h6e,8'h1c,8'h6a,8'h7c,
		8'h43,8'h28,8'h1e
	};

	// BCH(63,56) generator rows, one per information bit, MSB of byte 0 first
	localparam logic [7:0] GEN_ROWS [0:55] = '{
		8'hc4,8'h62,8'hf4,8'h7a,8'hf8,8'h7c,8'h3e,
		8'hda,8'ha8,8'h54,8'h2a,8'hd0,8'h68,8'h34,
		8'h1a,8'hc8,8'h64,8'h32,8'hdc,8'h6e,8'hf2,
		8'hbc,8'h5e,8'hea,8'hb0,8'h58,8'h2c,8'h16,
		8'hce,8'ha2,8'h94,8'h4a,8'he0,8'h70,8'h38,
		8'h1c,8'h0e,8'hc2,8'ha4,8'h52,8'hec,8'h76,
		8'hfe,8'hba,8'h98,8'h4c,8'h26,8'hd6,8'hae,
		8'h92,8'h8c,8'h46,8'he6,8'hb6,8'h9e,8'h8a
	};

	// Parity contribution of one byte at a given place in the codeblock
	function automatic logic [7:0] parity_contrib(input logic [2:0] blk, input logic [7:0] b);
		logic [7:0] acc;
		acc = '0;
		for (int k = 0; k < 8; k++) begin
			if (b[7-k])
				acc = acc ^ GEN_ROWS[{blk, 3'(k)}];
		end
		return acc;
	endfunction

	// One classified frame byte, as queued between front and back
	typedef struct packed {
		logic       start;
		logic [7:0] data;
		logic       par_en;
		logic [7:0] par;
		logic       tail;
	} cmd_t;

	// Back-end expansion phases
	typedef enum logic [2:0] {
		PH_NEW,
		PH_START0,
		PH_START1,
		PH_DATA,
		PH_PARITY,
		PH_TAIL
	} phase_t;

endpackage

// ----- src/tc_cltu_encoder_top.sv -----
// ----------------------------------------------------------------------------
// Telecommand CLTU encoder, BCH(63,56)
// Randomises frame bytes and wraps them into a CLTU: start sequence,
// codeblocks with parity bytes, and the tail sequence.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+--------------------------------------
//  config   | cfg_valid / cfg_ready   | randomize_enable
//  input    | in_valid / in_stall     | frame_byte
//  output   | out_valid / out_stall   | out_byte, byte_kind, run_last,
//           |                         | frame_end
//
// Each frame byte produces one to ten output beats; the back end emits one
// beat per cycle unless the output is stalled. The front end classifies a byte
// in the cycle it is accepted; a four-entry command queue lets it run ahead
// while the output is stalled. When the back end is idle, an accepted byte is
// written into the command queue and its first beat then passes through the
// output register before it is presented.
// Reset clears all counters, empties the queue and sets randomisation on.
// ----------------------------------------------------------------------------
module tc_cltu_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       randomize_enable,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] frame_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] byte_kind,
	output logic       run_last,
	output logic       frame_end
);
	import tcc_pkg::*;

	cmd_t wr_cmd;
	cmd_t rd_cmd;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;

	tcc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (randomize_enable),
		.in_valid   (in_valid),
		.frame_byte (frame_byte),
		.q_full     (q_full),
		.push       (push),
		.cmd        (wr_cmd)
	);

	tcc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	tcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (rd_cmd),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.byte_kind (byte_kind),
		.run_last  (run_last),
		.frame_end (frame_end)
	);

endmodule

// ----- src/tcc_front.sv -----
// ----------------------------------------------------------------------------
// CLTU encoder front end
// Takes frame bytes, randomises them, keeps the frame and codeblock counters
// and the parity accumulator, and issues one command per byte.
// ----------------------------------------------------------------------------
module tcc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_data,
	input  logic               in_valid,
	input  logic [7:0]         frame_byte,
	input  logic               q_full,
	output logic               push,
	output tcc_pkg::cmd_t      cmd
);
	import tcc_pkg::*;

	logic              rand_en_q;
	logic [FPOS_W-1:0] fpos_q;
	logic [7:0]        noise_q;
	logic [2:0]        blk_q;
	logic [7:0]        acc_q;

	logic [7:0]        rnd_byte;
	logic [7:0]        acc_nxt;
	logic [FPOS_W:0]   fpos_inc;
	logic              last;
	logic              close_blk;

	// Randomiser enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rand_en_q <= 1'b1;
		else if (cfg_valid)
			rand_en_q <= cfg_data;
	end

	// Classification of the incoming beat
	always_comb begin
		push      = in_valid && !q_full;
		rnd_byte  = rand_en_q ? (frame_byte ^ PN_SEQ[noise_q]) : frame_byte;
		acc_nxt   = acc_q ^ parity_contrib(blk_q, rnd_byte);
		fpos_inc  = {1'b0, fpos_q} + (FPOS_W+1)'(1);
		last      = fpos_inc >= (FPOS_W+1)'(FRAME_BYTES);
		close_blk = (blk_q == 3'(BLOCK_BYTES - 1)) || last;

		cmd.start  = (fpos_q == '0);
		cmd.data   = rnd_byte;
		cmd.par_en = close_blk;
		cmd.par    = ~acc_nxt & PARITY_MASK;
		cmd.tail   = last;
	end

	// Frame and codeblock counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpos_q  <= '0;
			noise_q <= '0;
			blk_q   <= '0;
			acc_q   <= '0;
		end else if (push) begin
			if (last) begin
				fpos_q  <= '0;
				noise_q <= '0;
			end else begin
				fpos_q  <= fpos_inc[FPOS_W-1:0];
				noise_q <= (noise_q == 8'(PN_LEN - 1)) ? 8'd0 : noise_q + 8'd1;
			end
			if (close_blk) begin
				blk_q <= '0;
				acc_q <= '0;
			end else begin
				blk_q <= blk_q + 3'd1;
				acc_q <= acc_nxt;
			end
		end
	end

endmodule

// ----- src/tcc_queue.sv -----
// ----------------------------------------------------------------------------
// CLTU encoder command queue
// A short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tcc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcc_pkg::cmd_t wr_cmd,
	input  logic          pop,
	output tcc_pkg::cmd_t rd_cmd,
	output logic          full,
	output logic          empty
);
	import tcc_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	// Status and head
	assign full   = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty  = (count_q == '0);
	assign rd_cmd = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	// Neither side may overrun the queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

// ----- src/tcc_back.sv -----
// ----------------------------------------------------------------------------
// CLTU encoder back end
// Expands each queued command into start, data, parity and tail beats and
// holds them in an output register.
// ----------------------------------------------------------------------------
module tcc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  tcc_pkg::cmd_t head,
	input  logic          q_empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic [1:0]    byte_kind,
	output logic          run_last,
	output logic          frame_end
);
	import tcc_pkg::*;

	phase_t     phase_q;
	phase_t     cur_ph;
	phase_t     nxt_ph;
	logic [2:0] tail_cnt_q;
	logic       done;
	logic       load;
	logic       adv;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [1:0] byte_kind_q;
	logic       run_last_q;
	logic       frame_end_q;

	logic [7:0] beat_byte;
	logic [1:0] beat_kind;
	logic       beat_end;

	// Output register may take a new beat when empty or being drained
	assign load = !out_valid_q || !out_stall;
	assign adv  = load && !q_empty;
	assign pop  = adv && done;

	// Next phase
	always_comb begin
		if (phase_q == PH_NEW)
			cur_ph = head.start ? PH_START0 : PH_DATA;
		else
			cur_ph = phase_q;
		done   = 1'b0;
		nxt_ph = PH_NEW;
		case (cur_ph)
			PH_START0: nxt_ph = PH_START1;
			PH_START1: nxt_ph = PH_DATA;
			PH_DATA: begin
				if (head.par_en)
					nxt_ph = PH_PARITY;
				else if (head.tail)
					nxt_ph = PH_TAIL;
				else
					done = 1'b1;
			end
			PH_PARITY: begin
				if (head.tail)
					nxt_ph = PH_TAIL;
				else
					done = 1'b1;
			end
			PH_TAIL: begin
				if (tail_cnt_q == TAIL_LAST)
					done = 1'b1;
				else
					nxt_ph = PH_TAIL;
			end
			default: nxt_ph = PH_NEW;
		endcase
	end

	// Beat contents for the current phase
	always_comb begin
		beat_byte = head.data;
		beat_kind = KIND_DATA;
		beat_end  = 1'b0;
		case (cur_ph)
			PH_START0: begin
				beat_byte = START_HI;
				beat_kind = KIND_START;
			end
			PH_START1: begin
				beat_byte = START_LO;
				beat_kind = KIND_START;
			end
			PH_DATA: begin
				beat_byte = head.data;
				beat_kind = KIND_DATA;
			end
			PH_PARITY: begin
				beat_byte = head.par;
				beat_kind = KIND_PARITY;
			end
			PH_TAIL: begin
				beat_kind = KIND_TAIL;
				beat_end  = (tail_cnt_q == TAIL_LAST);
				beat_byte = beat_end ? TAIL_END : TAIL_FILL;
			end
			default: beat_byte = head.data;
		endcase
	end

	// Phase and tail counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_NEW;
			tail_cnt_q <= '0;
		end else if (adv) begin
			phase_q <= nxt_ph;
			if (cur_ph == PH_TAIL)
				tail_cnt_q <= tail_cnt_q + 3'd1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= !q_empty;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q  <= beat_byte;
			byte_kind_q <= beat_kind;
			run_last_q  <= done;
			frame_end_q <= beat_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign byte_kind = byte_kind_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

`ifndef SYNTHESIS
	// A command being expanded stays at the head of the queue.
	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_NEW |-> !q_empty) else $error("command lost mid-expansion");
	// The tail counter only runs during the tail sequence.
	a_tail_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		tail_cnt_q != '0 |-> phase_q == PH_TAIL) else $error("stray tail count");
	// The end of a frame closes the command that caused it.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last && byte_kind == KIND_TAIL)
		else $error("frame end not on last tail beat");
`endif

endmodule
